// ===== hw/rtl/awm_pkg.sv =====
package awm_pkg;

  localparam int WINDOW_DEPTH = 256;
  localparam int SAMPLE_BITS  = 20;
  localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
  localparam int CNT_W        = 9;
  localparam int SUM_W        = 28;
  localparam int SQ_W         = 48;
  localparam int DEV_W        = SAMPLE_BITS + 1;
  localparam int DIV_STEPS    = SQ_W;
  localparam int ROOT_W       = SQ_W / 2;
  localparam int REM_W        = ROOT_W + 3;
  localparam int DRAIN_CYCLES = 4;
  localparam int STEP_W       = 6;

  typedef struct packed {
    logic sample_we;
    logic div_load_mean;
    logic div_load_sq;
    logic div_step;
    logic mean_take;
    logic pass_rd;
    logic sq_take;
    logic sqrt_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic close;
    logic pass_last;
    logic out_free;
  } status_t;

endpackage

// ===== hw/rtl/awm_if.sv =====
interface awm_in_if;
  import awm_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last;
  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

interface awm_out_if;
  import awm_pkg::*;
  logic                          valid;
  logic                          ready;
  logic [19:0]                   rms;
  logic [19:0]                   peak;
  logic signed [SAMPLE_BITS-1:0] mean;
  logic signed [SAMPLE_BITS-1:0] min_sample;
  logic signed [SAMPLE_BITS-1:0] max_sample;
  logic [19:0]                   span;
  logic                          active;
  logic [CNT_W-1:0]              sample_count;
  modport source (output valid, output rms, output peak, output mean, output min_sample,
                  output max_sample, output span, output active, output sample_count,
                  input ready);
  modport sink (input valid, input rms, input peak, input mean, input min_sample,
                input max_sample, input span, input active, input sample_count,
                output ready);
endinterface

// ===== hw/rtl/awm_ram.sv =====
module awm_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end
endmodule

// ===== hw/rtl/awm_ctrl.sv =====
module awm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  awm_pkg::status_t status,
  output awm_pkg::cmd_t    cmd
);
  import awm_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD, S_DIVM, S_PASS, S_DRAIN, S_DIVS, S_SQRT, S_EMIT
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] step;

  localparam logic [STEP_W-1:0] DIV_END   = STEP_W'(DIV_STEPS + 1);
  localparam logic [STEP_W-1:0] DRAIN_END = STEP_W'(DRAIN_CYCLES - 1);
  localparam logic [STEP_W-1:0] SQRT_END  = STEP_W'(ROOT_W - 1);

  assign in_ready = (state == S_LOAD);

  always_comb begin
    cmd               = '0;
    cmd.sample_we     = (state == S_LOAD) && in_valid;
    cmd.div_load_mean = (state == S_DIVM) && (step == '0);
    cmd.div_load_sq   = (state == S_DIVS) && (step == '0);
    cmd.div_step      = (state == S_DIVM || state == S_DIVS) && (step != '0) &&
                        (step != DIV_END);
    cmd.mean_take     = (state == S_DIVM) && (step == DIV_END);
    cmd.sq_take       = (state == S_DIVS) && (step == DIV_END);
    cmd.pass_rd       = (state == S_PASS);
    cmd.sqrt_step     = (state == S_SQRT);
    cmd.emit          = (state == S_EMIT) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      step  <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          step <= '0;
          if (in_valid && status.close) state <= S_DIVM;
        end
        S_DIVM: begin
          if (step == DIV_END) begin
            step  <= '0;
            state <= S_PASS;
          end else step <= step + 1'b1;
        end
        S_PASS: begin
          if (status.pass_last) state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (step == DRAIN_END) begin
            step  <= '0;
            state <= S_DIVS;
          end else step <= step + 1'b1;
        end
        S_DIVS: begin
          if (step == DIV_END) begin
            step  <= '0;
            state <= S_SQRT;
          end else step <= step + 1'b1;
        end
        S_SQRT: begin
          if (step == SQRT_END) begin
            step  <= '0;
            state <= S_EMIT;
          end else step <= step + 1'b1;
        end
        S_EMIT: begin
          if (status.out_free) state <= S_LOAD;
        end
        default: begin
          state <= S_LOAD;
          step  <= '0;
        end
      endcase
    end
  end
endmodule

// ===== hw/rtl/awm_datapath.sv =====
module awm_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  awm_pkg::cmd_t                          cmd,
  output awm_pkg::status_t                       status,
  input  logic signed [awm_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                   last,
  input  logic [19:0]                            min_span,
  input  logic [19:0]                            rms_floor,
  awm_out_if.source                              results
);
  import awm_pkg::*;

  logic [CNT_W-1:0]              fill;
  logic [CNT_W-1:0]              n;
  logic signed [SUM_W-1:0]       sum;
  logic signed [SAMPLE_BITS-1:0] lo, hi, mean;
  logic                          neg;
  logic [SQ_W-1:0]               dq;
  logic [CNT_W-1:0]              dr;
  logic [CNT_W:0]                dtrial;
  logic [ADDR_W-1:0]             addr;
  logic [SAMPLE_BITS-1:0]        rd_data;
  logic                          v1, v2, v3;
  logic [DEV_W-1:0]              mag, peak;
  logic signed [DEV_W-1:0]       dev;
  logic [2*DEV_W-1:0]            sq;
  logic [SQ_W-1:0]               sqsum;
  logic [SQ_W-1:0]               sx;
  logic [REM_W-1:0]              srem, srem_shift, strial;
  logic [ROOT_W-1:0]             root;
  logic [SUM_W-1:0]              sum_abs;
  logic [DEV_W-1:0]              span_w;
  logic [19:0]                   mean_mag;
  logic                          ovalid;

  assign status.close     = last || (fill == CNT_W'(WINDOW_DEPTH - 1));
  assign status.pass_last = (addr == ADDR_W'(n - 1'b1));
  assign status.out_free  = !ovalid || results.ready;

  awm_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW_DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (cmd.sample_we),
    .wr_addr (fill[ADDR_W-1:0]),
    .wr_data (sample),
    .rd_en   (cmd.pass_rd),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  assign sum_abs    = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign dtrial     = {dr, dq[SQ_W-1]};
  assign mean_mag   = dq[19:0];
  assign dev        = DEV_W'($signed(rd_data)) - DEV_W'(mean);
  assign srem_shift = {srem[REM_W-3:0], sx[SQ_W-1 -: 2]};
  assign strial     = {1'b0, root, 2'b01};
  assign span_w     = DEV_W'(hi) - DEV_W'(lo);

  // window load: running stats as items arrive
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.sample_we) begin
      fill <= status.close ? '0 : fill + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sample_we) begin
      if (status.close) n <= fill + 1'b1;
      if (fill == '0) begin
        sum <= SUM_W'(sample);
        lo  <= sample;
        hi  <= sample;
      end else begin
        sum <= sum + SUM_W'(sample);
        if (sample < lo) lo <= sample;
        if (sample > hi) hi <= sample;
      end
    end
  end

  // shared restoring divider, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.div_load_mean) begin
      dq  <= SQ_W'(sum_abs);
      dr  <= '0;
      neg <= sum[SUM_W-1];
    end else if (cmd.div_load_sq) begin
      dq <= sqsum;
      dr <= '0;
    end else if (cmd.div_step) begin
      if (dtrial >= {1'b0, n}) begin
        dr <= CNT_W'(dtrial - {1'b0, n});
        dq <= {dq[SQ_W-2:0], 1'b1};
      end else begin
        dr <= dtrial[CNT_W-1:0];
        dq <= {dq[SQ_W-2:0], 1'b0};
      end
    end
  end

  // second pass: read, deviation, square, accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.pass_rd;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mean_take) begin
      mean  <= neg ? SAMPLE_BITS'(-mean_mag) : SAMPLE_BITS'(mean_mag);
      addr  <= '0;
      peak  <= '0;
      sqsum <= '0;
    end else begin
      if (cmd.pass_rd) addr <= addr + 1'b1;
      if (v1) mag <= dev[DEV_W-1] ? DEV_W'(-dev) : DEV_W'(dev);
      if (v2) begin
        sq <= mag * mag;
        if (mag > peak) peak <= mag;
      end
      if (v3) sqsum <= sqsum + SQ_W'(sq);
    end
  end

  // bit-by-bit square root, two radicand bits a cycle
  always_ff @(posedge clk) begin
    if (cmd.sq_take) begin
      sx   <= dq;
      srem <= '0;
      root <= '0;
    end else if (cmd.sqrt_step) begin
      sx <= {sx[SQ_W-3:0], 2'b00};
      if (strial <= srem_shift) begin
        srem <= srem_shift - strial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        srem <= srem_shift;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (cmd.emit) begin
      ovalid <= 1'b1;
    end else if (results.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      results.rms          <= root[19:0];
      results.peak         <= peak[19:0];
      results.mean         <= mean;
      results.min_sample   <= lo;
      results.max_sample   <= hi;
      results.span         <= span_w[19:0];
      results.active       <= (span_w >= DEV_W'(min_span)) &&
                              (root >= ROOT_W'(rms_floor));
      results.sample_count <= n;
    end
  end

  assign results.valid = ovalid;
endmodule

// ===== hw/rtl/audio_window_level_meter.sv =====
// audio window level meter
// samples: one signed pcm sample per item with a last flag. the window
// closes on last, or on the sample that fills all 256 slots of the store.
// results: one item per closed window with rms, peak deviation, mean,
// min, max, span, activity flag and sample count.
// loading takes one sample item per cycle into the window ram.
// after the closing item, input is held off while the window is analysed:
// the mean divide (one quotient bit per cycle), the deviation pass over the
// ram plus a pipeline drain, the mean-square divide and the square root, two
// radicand bits per cycle.
// the result sits in an output register; if the receiver stalls, loading of
// the next window goes on and only the next window's result waits for it.
// reset (synchronous, active high) empties the window, drops a pending
// result and sets min_span to 8 and rms_floor to 16.
// apb: min_span at address 0, rms_floor at address 4, pready always high.
module audio_window_level_meter (
  input  logic        clk,
  input  logic        rst,
  awm_in_if.sink      samples,
  awm_out_if.source   results,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import awm_pkg::*;

  logic [19:0] min_span, rms_floor;
  cmd_t        cmd;
  status_t     status;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? {12'd0, rms_floor} : {12'd0, min_span};

  always_ff @(posedge clk) begin
    if (rst) begin
      min_span  <= 20'd8;
      rms_floor <= 20'd16;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) rms_floor <= pwdata[19:0];
      else          min_span  <= pwdata[19:0];
    end
  end

  awm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .status   (status),
    .cmd      (cmd)
  );

  awm_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .sample    (samples.sample),
    .last      (samples.last),
    .min_span  (min_span),
    .rms_floor (rms_floor),
    .results   (results)
  );
endmodule

// ===== test/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import awm_pkg::*;

  localparam logic [2:0] MIN_SPAN_ADDR  = 3'd0;
  localparam logic [2:0] RMS_FLOOR_ADDR = 3'd4;
  localparam int DRAIN_WAIT = 400;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [19:0]                   rms;
    logic [19:0]                   peak;
    logic signed [SAMPLE_BITS-1:0] mean;
    logic signed [SAMPLE_BITS-1:0] min_sample;
    logic signed [SAMPLE_BITS-1:0] max_sample;
    logic [19:0]                   span;
    logic                          active;
    logic [CNT_W-1:0]              sample_count;
  } level_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  awm_in_if  samples_if();
  awm_out_if results_if();

  audio_window_level_meter DUT (
    .clk(clk), .rst(rst), .samples(samples_if), .results(results_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // level predictor state
  logic signed [SAMPLE_BITS-1:0] win_samples [WINDOW_DEPTH];
  int          win_fill;
  longint      win_sum;
  logic signed [SAMPLE_BITS-1:0] win_lo, win_hi;
  logic [19:0] span_min_cfg;
  logic [19:0] rms_floor_cfg;
  level_t      level_q[$];

  int errors;
  int snd_idle_pct;
  int rcv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  function automatic logic [19:0] floor_root(input longint unsigned v);
    longint unsigned r, t;
    r = 0;
    for (int b = 23; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r[19:0];
  endfunction

  task automatic absorb_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic l);
    level_t lv;
    longint m, d;
    longint unsigned mag, sq, pk;
    if (win_fill == 0) begin
      win_lo = s;
      win_hi = s;
      win_sum = 0;
    end
    win_samples[win_fill] = s;
    win_fill++;
    win_sum += s;
    if (s < win_lo) win_lo = s;
    if (s > win_hi) win_hi = s;
    if (!l && win_fill < WINDOW_DEPTH) return;
    // closing item: second pass over the window
    m = win_sum / longint'(win_fill);
    sq = 0;
    pk = 0;
    for (int i = 0; i < win_fill; i++) begin
      d = longint'(win_samples[i]) - m;
      mag = (d < 0) ? -d : d;
      if (mag > pk) pk = mag;
      sq += mag * mag;
    end
    lv.rms = floor_root(sq / longint'(win_fill));
    lv.peak = pk[19:0];
    lv.mean = m[19:0];
    lv.min_sample = win_lo;
    lv.max_sample = win_hi;
    lv.span = 20'(longint'(win_hi) - longint'(win_lo));
    lv.active = (lv.span >= span_min_cfg) && (lv.rms >= rms_floor_cfg);
    lv.sample_count = CNT_W'(win_fill);
    level_q.push_back(lv);
    win_fill = 0;
  endtask

  always @(posedge clk) begin
    if (!rst && samples_if.valid && samples_if.ready)
      absorb_sample(samples_if.sample, samples_if.last);
  end

  always @(posedge clk) begin
    results_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  always @(posedge clk) begin
    level_t want;
    if (!rst && results_if.valid && results_if.ready) begin
      if (level_q.size() == 0) begin
        report("unexpected result", results_if.sample_count, 0);
      end else begin
        want = level_q.pop_front();
        if (results_if.rms !== want.rms) report("rms", results_if.rms, want.rms);
        if (results_if.peak !== want.peak) report("peak", results_if.peak, want.peak);
        if (results_if.mean !== want.mean) report("mean", results_if.mean, want.mean);
        if (results_if.min_sample !== want.min_sample)
          report("min_sample", results_if.min_sample, want.min_sample);
        if (results_if.max_sample !== want.max_sample)
          report("max_sample", results_if.max_sample, want.max_sample);
        if (results_if.span !== want.span) report("span", results_if.span, want.span);
        if (results_if.active !== want.active)
          report("active", results_if.active, want.active);
        if (results_if.sample_count !== want.sample_count)
          report("sample_count", results_if.sample_count, want.sample_count);
      end
    end
  end

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == MIN_SPAN_ADDR) span_min_cfg = val[19:0];
    else rms_floor_cfg = val[19:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_read(input logic [2:0] addr, output logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    val = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // valid stays high after an item unless the next call idles first
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic l);
    while ($urandom_range(99) < snd_idle_pct) begin
      samples_if.valid <= 1'b0;
      @(posedge clk);
    end
    samples_if.valid <= 1'b1;
    samples_if.sample <= s;
    samples_if.last <= l;
    @(posedge clk);
    while (!samples_if.ready) @(posedge clk);
  endtask

  task automatic drain;
    samples_if.valid <= 1'b0;
    @(posedge clk);
    while (level_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input int wide,
                                                                input int center,
                                                                input int amp);
    int v;
    if (wide != 0) return SAMPLE_BITS'($urandom);
    v = center + $urandom_range(2 * amp) - amp;
    if (v > 524287) v = 524287;
    if (v < -524288) v = -524288;
    return v[SAMPLE_BITS-1:0];
  endfunction

  task automatic send_window(input int len);
    int wide, center, amp;
    wide = ($urandom_range(3) == 0);
    center = $urandom_range(1048575) - 524288;
    amp = (1 << $urandom_range(12)) - 1;
    for (int i = 0; i < len; i++)
      send_sample(pick_sample(wide, center, amp), i == len - 1);
  endtask

  task automatic test_registers;
    logic [31:0] rd;
    reg_read(MIN_SPAN_ADDR, rd);
    if (rd[19:0] !== 20'd8) report("min_span reset", rd, 8);
    reg_read(RMS_FLOOR_ADDR, rd);
    if (rd[19:0] !== 20'd16) report("rms_floor reset", rd, 16);
    reg_write(MIN_SPAN_ADDR, 32'hFFFFF);
    reg_write(RMS_FLOOR_ADDR, 32'h12345);
    reg_read(MIN_SPAN_ADDR, rd);
    if (rd[19:0] !== 20'hFFFFF) report("min_span", rd, 20'hFFFFF);
    reg_read(RMS_FLOOR_ADDR, rd);
    if (rd[19:0] !== 20'h12345) report("rms_floor", rd, 20'h12345);
    reg_write(MIN_SPAN_ADDR, 32'd8);
    reg_write(RMS_FLOOR_ADDR, 32'd16);
  endtask

  task automatic test_directed;
    send_sample(20'sh7FFFF, 1'b1);
    send_sample(-20'sh80000, 1'b1);
    // full-scale span, mean rounds toward zero
    send_sample(-20'sh80000, 1'b0);
    send_sample(20'sh7FFFF, 1'b1);
    send_sample(-20'sd3, 1'b0);
    send_sample(-20'sd4, 1'b1);
    send_sample(20'sh55555, 1'b0);
    send_sample(20'shAAAAA, 1'b1);
    send_sample(20'sd100, 1'b0);
    send_sample(20'sd100, 1'b0);
    send_sample(20'sd100, 1'b1);
    // exactly at the rms floor, then just under it, then a span just under min_span
    send_sample(-20'sd16, 1'b0);
    send_sample(20'sd16, 1'b1);
    send_sample(-20'sd15, 1'b0);
    send_sample(20'sd15, 1'b1);
    send_sample(-20'sd4, 1'b0);
    send_sample(20'sd3, 1'b1);
    drain();
    reg_write(MIN_SPAN_ADDR, 32'd0);
    reg_write(RMS_FLOOR_ADDR, 32'd0);
    send_sample(20'sd7, 1'b1);
    send_sample(20'sd0, 1'b1);
    drain();
    reg_write(MIN_SPAN_ADDR, 32'hFFFFF);
    reg_write(RMS_FLOOR_ADDR, 32'hFFFFF);
    send_sample(-20'sh80000, 1'b0);
    send_sample(20'sh7FFFF, 1'b1);
    drain();
  endtask

  // no last flag until past the store size: the full store closes the window
  task automatic test_window_full;
    reg_write(MIN_SPAN_ADDR, 32'd8);
    reg_write(RMS_FLOOR_ADDR, 32'd16);
    for (int i = 0; i < WINDOW_DEPTH + 4; i++)
      send_sample(pick_sample(1, 0, 0), i == WINDOW_DEPTH + 3);
    drain();
  endtask

  task automatic test_random;
    int sent, len, sel;
    int snd_pct[4] = '{0, 83, 0, 14};
    int rcv_pct[4] = '{0, 0, 83, 14};
    for (int ph = 0; ph < 4; ph++) begin
      snd_idle_pct = snd_pct[ph];
      rcv_stall_pct = rcv_pct[ph];
      case (ph)
        0: begin
          reg_write(MIN_SPAN_ADDR, 32'd0);
          reg_write(RMS_FLOOR_ADDR, 32'd0);
        end
        1: begin
          reg_write(MIN_SPAN_ADDR, $urandom_range(64));
          reg_write(RMS_FLOOR_ADDR, $urandom_range(64));
        end
        2: begin
          reg_write(MIN_SPAN_ADDR, $urandom_range(4096));
          reg_write(RMS_FLOOR_ADDR, $urandom_range(1024));
        end
        default: begin
          reg_write(MIN_SPAN_ADDR, 32'hFFFFF);
          reg_write(RMS_FLOOR_ADDR, $urandom);
        end
      endcase
      sent = 0;
      while (sent < 190) begin
        sel = $urandom_range(99);
        if (sel < 85) len = $urandom_range(1, 16);
        else if (sel < 97) len = $urandom_range(17, 64);
        else len = $urandom_range(240, 300);
        send_window(len);
        sent += len;
      end
      drain();
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    samples_if.valid = 1'b0;
    samples_if.sample = '0;
    samples_if.last = 1'b0;
    results_if.ready = 1'b0;
    errors = 0;
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    win_fill = 0;
    win_sum = 0;
    win_lo = '0;
    win_hi = '0;
    span_min_cfg = 20'd8;
    rms_floor_cfg = 20'd16;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_registers();
    test_directed();
    test_window_full();
    test_random();
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

endmodule
